@@ rtl/ticket_dispense_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// ticket dispense sequencer assertion macros
// ----------------------------------------------------------------------------
`ifndef TICKET_DISPENSE_SEQUENCER_MACROS_SVH
`define TICKET_DISPENSE_SEQUENCER_MACROS_SVH

// check on every clock edge outside reset
`define TDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check on every clock edge, reset included
`define TDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/tds_pkg.sv @@
// ----------------------------------------------------------------------------
// tds_pkg
// Types and constants shared by the ticket dispense sequencer.
// ----------------------------------------------------------------------------
package tds_pkg;

    // width of the owed count and the sensor run counters
    localparam int COUNT_BITS = 16;
    // configuration register width
    localparam int CFG_W      = 16;
    // width used for run length compares
    localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int ADDED_W    = 8;
    localparam int PENDING_W  = 16;
    localparam int TOTAL_W    = 32;
    localparam int PHASE_W    = 2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] CONFIRM_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] STALL_RESET   = CFG_W'(200);

    // configuration register indexes
    typedef enum logic {
        REG_CONFIRM_TICKS = 1'b0,
        REG_STALL_TICKS   = 1'b1
    } cfg_reg_t;

    // sequencer phase
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_ON    = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // one result item
    typedef struct packed {
        logic                 stop_drive;
        logic [PENDING_W-1:0] pending_count;
        logic [TOTAL_W-1:0]   dispensed_total;
        phase_t               phase;
    } result_t;

endpackage

@@ rtl/ticket_dispense_sequencer.sv @@
// ----------------------------------------------------------------------------
// ticket_dispense_sequencer
// Drives a ticket dispenser from millisecond tick items and counts tickets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per millisecond tick with
//   the sensor level and the number of tickets newly owed.
//   Output channel (out_valid / out_stall): one result item per input item,
//   with drive level, tickets still owed, wrapping total and phase.
//   Configuration: cfg_we writes cfg_data to the register chosen by
//   cfg_index (0 confirm_ticks, 1 stall_ticks); write only while idle.
// Timing:
//   The state update is done in the cycle the item is accepted; the result
//   is offered from the cycle after. One item per cycle is sustained while out_stall is low.
//   A two-entry result queue sits between the sides, so a new item is taken
//   while an older result waits; in_stall rises only when both are full.
// Reset:
//   Phase idle, drive stopped, counters and total zero, confirm_ticks 4,
//   stall_ticks 200, result queue empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ticket_dispense_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tds_pkg::CFG_W-1:0]     cfg_data,
    // tick items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          sensor_level,
    input  logic [tds_pkg::ADDED_W-1:0]   tickets_added,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          stop_drive,
    output logic [tds_pkg::PENDING_W-1:0] pending_count,
    output logic [tds_pkg::TOTAL_W-1:0]   dispensed_total,
    output logic [tds_pkg::PHASE_W-1:0]   phase
);

    import tds_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // configuration registers
    logic [CFG_W-1:0]      confirm_reg;
    logic [CFG_W-1:0]      stall_reg;

    // sequencer state
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] high_reg;
    logic [COUNT_BITS-1:0] high_next;
    logic [COUNT_BITS-1:0] low_reg;
    logic [COUNT_BITS-1:0] low_next;
    logic [COUNT_BITS-1:0] owed_reg;
    logic [COUNT_BITS-1:0] owed_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic                  drive_reg;
    logic                  drive_next;

    // intermediate values of one step
    logic [COUNT_BITS:0]   owed_sum;
    logic [COUNT_BITS-1:0] owed_add;
    logic [COUNT_BITS-1:0] high_upd;
    logic [COUNT_BITS-1:0] low_upd;
    logic                  owed_none;
    logic                  confirm_high;
    logic                  confirm_low;
    logic                  stall_hit;
    result_t               result;

    // result queue
    result_t               queue_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  in_accept;
    logic                  out_accept;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= CONFIRM_RESET;
            stall_reg   <= STALL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CONFIRM_TICKS: confirm_reg <= cfg_data;
                REG_STALL_TICKS:   stall_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // owed count, saturating add
    assign owed_sum  = {1'b0, owed_reg} + (COUNT_BITS+1)'(tickets_added);
    assign owed_add  = owed_sum[COUNT_BITS] ? CNT_MAX : owed_sum[COUNT_BITS-1:0];
    assign owed_none = (owed_add == '0);

    // sensor run counters, saturating
    assign high_upd = !sensor_level ? '0 :
                      (high_reg == CNT_MAX) ? CNT_MAX : high_reg + 1'b1;
    assign low_upd  = sensor_level ? '0 :
                      (low_reg == CNT_MAX) ? CNT_MAX : low_reg + 1'b1;

    // confirm compares on the updated runs
    assign confirm_high = (CMP_W'(high_upd) >= CMP_W'(confirm_reg));
    assign confirm_low  = (CMP_W'(low_upd) >= CMP_W'(confirm_reg));
    // stall compare on the run as left after the phase step
    assign stall_hit    = (CMP_W'(high_next) >= CMP_W'(stall_reg));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (owed_none)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:  phase_next = PH_START;
                PH_START: if (confirm_high) phase_next = PH_ON;
                PH_ON:    if (confirm_low) phase_next = PH_STOP;
                PH_STOP:  phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
            if (stall_hit)
                phase_next = PH_IDLE;
        end
    end

    // counters, drive and total
    always_comb
    begin
        high_next  = high_upd;
        low_next   = low_upd;
        owed_next  = owed_add;
        total_next = total_reg;
        drive_next = drive_reg;
        if (owed_none)
        begin
            drive_next = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    drive_next = 1'b0;
                    high_next  = '0;
                    low_next   = '0;
                end
                PH_STOP:
                begin
                    // owed is nonzero here, so the retire never wraps
                    owed_next  = owed_add - 1'b1;
                    total_next = total_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // state registers, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            high_reg  <= '0;
            low_reg   <= '0;
            owed_reg  <= '0;
            total_reg <= '0;
            drive_reg <= 1'b1;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            owed_reg  <= owed_next;
            total_reg <= total_next;
            drive_reg <= drive_next;
        end
    end

    // result item of this step
    always_comb
    begin
        result.stop_drive      = drive_next;
        result.pending_count   = PENDING_W'(owed_next);
        result.dispensed_total = total_next;
        result.phase           = phase_next;
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            queue_reg[wr_ptr_reg] <= result;
    end

    // result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (in_accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (out_accept)
                rd_ptr_reg <= !rd_ptr_reg;
            if (in_accept && !out_accept)
                count_reg <= count_reg + 2'd1;
            else if (!in_accept && out_accept)
                count_reg <= count_reg - 2'd1;
        end
    end

    // handshake and output payload
    assign in_stall        = (count_reg == 2'd2);
    assign out_valid       = (count_reg != 2'd0);
    assign stop_drive      = queue_reg[rd_ptr_reg].stop_drive;
    assign pending_count   = queue_reg[rd_ptr_reg].pending_count;
    assign dispensed_total = queue_reg[rd_ptr_reg].dispensed_total;
    assign phase           = queue_reg[rd_ptr_reg].phase;

    // assertions
`include "ticket_dispense_sequencer_macros.svh"

    `TDS_ASSERT(a_queue_bound, (count_reg <= 2'd2), "result queue overfilled")
    `TDS_ASSERT_ALWAYS(a_busy_owes, ((phase_reg == PH_IDLE) || (owed_reg != '0)), "nothing owed")
    `TDS_ASSERT_ALWAYS(a_drive_in_cycle, ((phase_reg == PH_IDLE) || !drive_reg), "drive stopped")
    `TDS_ASSERT(a_total_step, (in_accept |=> ((total_reg - $past(total_reg)) <= 32'd1)), "total jump")

endmodule
